@@ design/lngh_pkg.sv @@
// Shared types and constants for the letter n-gram histogram.
// No dependencies; imported by the top level and the response stage.
`timescale 1ns / 1ps

package lngh_pkg;

	// Result count width on the output port.
	localparam int OUT_W = 32;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_CODE  = 1'd1;

	// Reset values of the code range: 'a' through 's'.
	localparam logic [7:0] FIRST_CODE_RST = 8'd97;
	localparam logic [7:0] LAST_CODE_RST  = 8'd115;

	// Operation codes of an input beat.
	typedef enum logic [1:0] {
		OP_FEED  = 2'd0,
		OP_READ  = 2'd1,
		OP_TOTAL = 2'd2
	} op_t;

	// Table select of a read.
	localparam logic [1:0] ORD_UNI = 2'd1;
	localparam logic [1:0] ORD_BI  = 2'd2;
	localparam logic [1:0] ORD_TRI = 2'd3;

	// Which value the response stage returns.
	typedef enum logic [2:0] {
		RES_ZERO  = 3'd0,
		RES_TOTAL = 3'd1,
		RES_UNI   = 3'd2,
		RES_BI    = 3'd3,
		RES_TRI   = 3'd4
	} res_sel_t;

	// Per-item control carried from the read stage to the write-back stage.
	typedef struct packed {
		logic     feed_hit;
		logic     use_bi;
		logic     use_tri;
		logic     acc;
		res_sel_t res;
	} item_ctl_t;

endpackage

@@ design/lngh_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lngh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/lngh_clear.sv @@
// Post-reset clearing sweep: walks every address once, one per cycle.
// No dependencies; drives the zero writes into the counter memories.
`timescale 1ns / 1ps

module lngh_clear #(
	parameter int ADDR_W = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	output logic              active,
	output logic [ADDR_W-1:0] addr
);

	logic              active_q;
	logic [ADDR_W-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			addr_q   <= '0;
		end else if (active_q) begin
			// stop after the last address has been written
			if (addr_q == '1) begin
				active_q <= 1'b0;
			end
			addr_q <= addr_q + ADDR_W'(1);
		end
	end

	assign active = active_q;
	assign addr   = addr_q;

endmodule

@@ design/lngh_resp.sv @@
// Response stage: selects the returned count, clips it and holds the output beat.
// Depends on lngh_pkg for the item control struct and the result select codes.
`timescale 1ns / 1ps

module lngh_resp
	import lngh_pkg::*;
#(
	parameter int COUNT_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  item_ctl_t             ctl,
	input  logic [COUNT_BITS-1:0] total_nxt,
	input  logic [COUNT_BITS-1:0] uni_cnt,
	input  logic [COUNT_BITS-1:0] bi_cnt,
	input  logic [COUNT_BITS-1:0] tri_cnt,
	input  logic                  out_stall,
	output logic                  out_free,
	output logic                  out_valid,
	output logic                  accepted,
	output logic [OUT_W-1:0]      count_value
);

	logic             out_valid_q;
	logic             accepted_q;
	logic [OUT_W-1:0] count_value_q;
	logic [OUT_W-1:0] res_val;

	// Clip a count to the output width.
	function automatic logic [OUT_W-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'hFFFF_FFFF) ? '1 : w[OUT_W-1:0];
	endfunction

	always_comb begin
		case (ctl.res)
			RES_TOTAL: res_val = clip_out(total_nxt);
			RES_UNI:   res_val = clip_out(uni_cnt);
			RES_BI:    res_val = clip_out(bi_cnt);
			RES_TRI:   res_val = clip_out(tri_cnt);
			default:   res_val = '0;
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			accepted_q    <= ctl.acc;
			count_value_q <= res_val;
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = accepted_q;
	assign count_value = count_value_q;

endmodule

@@ design/letter_ngram_histogram.sv @@
// Letter n-gram histogram top level: unigram, bigram and trigram counters in RAM.
// The input beat is registered in the write-back stage, and its result then in the output register.
// A new input beat is held off while an item sits in the write-back stage, for the
// read-modify-write turn of the counter RAMs (read in the accept cycle, written back at retire).
// Reset: code range returns to 'a'..'s', context and total clear, then a sweep
// zeroes all 2^(3*clog2(ALPHABET_SIZE)) RAM addresses (32768) with in_stall high.
`timescale 1ns / 1ps

module letter_ngram_histogram
	import lngh_pkg::*;
#(
	parameter int ALPHABET_SIZE = 32,
	parameter int COUNT_BITS    = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	// input beat
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [7:0]           byte_in,
	input  logic [1:0]           table_order,
	input  logic [4:0]           index_first,
	input  logic [4:0]           index_second,
	input  logic [4:0]           index_third,
	// result beat
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 accepted,
	output logic [OUT_W-1:0]     count_value
);

	// Symbol index width; bigram and trigram addresses concatenate symbols.
	localparam int SYM_W     = $clog2(ALPHABET_SIZE);
	localparam int BI_AW     = 2 * SYM_W;
	localparam int TRI_AW    = 3 * SYM_W;
	localparam int UNI_DEPTH = 1 << SYM_W;
	localparam int BI_DEPTH  = 1 << BI_AW;
	localparam int TRI_DEPTH = 1 << TRI_AW;
	localparam logic [8:0] BYTE_LIM = 9'(ALPHABET_SIZE);
	localparam logic [6:0] IDX_LIM  = 7'(ALPHABET_SIZE);

	// ------------------------------------------------------------------
	// Configuration and context registers
	// ------------------------------------------------------------------
	logic [7:0]            first_code_q;
	logic [7:0]            last_code_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [SYM_W-1:0]      recent_q;
	logic                  recent_valid_q;
	logic [SYM_W-1:0]      older_q;
	logic                  older_valid_q;

	// Clearing sweep
	logic              clr_active;
	logic [TRI_AW-1:0] clr_addr;

	lngh_clear #(
		.ADDR_W(TRI_AW)
	) u_clear (
		.clk   (clk),
		.arst_n(arst_n),
		.active(clr_active),
		.addr  (clr_addr)
	);

	// ------------------------------------------------------------------
	// Accept stage: decode the beat, issue RAM reads
	// ------------------------------------------------------------------
	logic              s1_valid_q;
	logic              s1_done;
	logic              out_free;
	logic              in_fire;
	logic [7:0]        diff;
	logic              in_range;
	logic [SYM_W-1:0]  sym_x;
	logic [SYM_W-1:0]  ri1;
	logic [SYM_W-1:0]  ri2;
	logic [SYM_W-1:0]  ri3;
	logic              ok1;
	logic              ok2;
	logic              ok3;
	logic              is_feed;
	item_ctl_t         ctl_in;
	logic [SYM_W-1:0]  uni_addr;
	logic [BI_AW-1:0]  bi_addr;
	logic [TRI_AW-1:0] tri_addr;

	// Hold off new beats during the sweep and while an item is in flight.
	assign in_stall = clr_active || s1_valid_q;
	assign in_fire  = in_valid && !in_stall;

	assign diff     = byte_in - first_code_q;
	assign in_range = (byte_in >= first_code_q) && (byte_in <= last_code_q) &&
	                  ({1'b0, diff} < BYTE_LIM);
	assign sym_x    = SYM_W'(diff);

	assign ri1 = SYM_W'(index_first);
	assign ri2 = SYM_W'(index_second);
	assign ri3 = SYM_W'(index_third);
	assign ok1 = {2'b00, index_first} < IDX_LIM;
	assign ok2 = {2'b00, index_second} < IDX_LIM;
	assign ok3 = {2'b00, index_third} < IDX_LIM;

	assign is_feed = (opcode == OP_FEED);

	always_comb begin
		ctl_in.feed_hit = 1'b0;
		ctl_in.use_bi   = 1'b0;
		ctl_in.use_tri  = 1'b0;
		ctl_in.acc      = 1'b1;
		ctl_in.res      = RES_ZERO;
		unique case (opcode)
			OP_FEED: begin
				// a skipped byte still reports the total, with accepted low
				ctl_in.feed_hit = in_range;
				ctl_in.use_bi   = in_range && recent_valid_q;
				ctl_in.use_tri  = in_range && recent_valid_q && older_valid_q;
				ctl_in.acc      = in_range;
				ctl_in.res      = RES_TOTAL;
			end
			OP_READ: begin
				case (table_order)
					ORD_UNI: ctl_in.res = ok3 ? RES_UNI : RES_ZERO;
					ORD_BI:  ctl_in.res = (ok2 && ok3) ? RES_BI : RES_ZERO;
					ORD_TRI: ctl_in.res = (ok1 && ok2 && ok3) ? RES_TRI : RES_ZERO;
					default: ctl_in.res = RES_ZERO;
				endcase
			end
			OP_TOTAL: begin
				ctl_in.res = RES_TOTAL;
			end
			default: begin
				// unused code: no update, zero result, accepted low
				ctl_in.acc = 1'b0;
			end
		endcase
	end

	// A feed addresses through the context; a read through the index fields.
	assign uni_addr = is_feed ? sym_x : ri3;
	assign bi_addr  = is_feed ? {recent_q, sym_x} : {ri2, ri3};
	assign tri_addr = is_feed ? {older_q, recent_q, sym_x} : {ri1, ri2, ri3};

	// ------------------------------------------------------------------
	// Write-back stage registers
	// ------------------------------------------------------------------
	item_ctl_t         ctl_s1;
	logic [SYM_W-1:0]  uni_addr_s1;
	logic [BI_AW-1:0]  bi_addr_s1;
	logic [TRI_AW-1:0] tri_addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_fire) begin
			s1_valid_q <= 1'b1;
		end else if (s1_done) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ctl_s1      <= ctl_in;
			uni_addr_s1 <= uni_addr;
			bi_addr_s1  <= bi_addr;
			tri_addr_s1 <= tri_addr;
		end
	end

	// Retire the item once the output register can take its result.
	assign s1_done = s1_valid_q && out_free;

	// ------------------------------------------------------------------
	// Counter RAMs
	// ------------------------------------------------------------------
	logic [COUNT_BITS-1:0] uni_rd;
	logic [COUNT_BITS-1:0] bi_rd;
	logic [COUNT_BITS-1:0] tri_rd;
	logic                  uni_we;
	logic                  bi_we;
	logic                  tri_we;
	logic [SYM_W-1:0]      uni_wa;
	logic [BI_AW-1:0]      bi_wa;
	logic [TRI_AW-1:0]     tri_wa;
	logic [COUNT_BITS-1:0] uni_wd;
	logic [COUNT_BITS-1:0] bi_wd;
	logic [COUNT_BITS-1:0] tri_wd;
	logic [COUNT_BITS-1:0] total_nxt;

	// Saturating increment.
	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : v + COUNT_BITS'(1);
	endfunction

	// The sweep owns the write ports; no item is in flight while it runs.
	assign uni_we = clr_active || (s1_done && ctl_s1.feed_hit);
	assign bi_we  = clr_active || (s1_done && ctl_s1.use_bi);
	assign tri_we = clr_active || (s1_done && ctl_s1.use_tri);
	assign uni_wa = clr_active ? clr_addr[SYM_W-1:0] : uni_addr_s1;
	assign bi_wa  = clr_active ? clr_addr[BI_AW-1:0] : bi_addr_s1;
	assign tri_wa = clr_active ? clr_addr : tri_addr_s1;
	assign uni_wd = clr_active ? '0 : sat_inc(uni_rd);
	assign bi_wd  = clr_active ? '0 : sat_inc(bi_rd);
	assign tri_wd = clr_active ? '0 : sat_inc(tri_rd);

	lngh_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(UNI_DEPTH)
	) u_uni_ram (
		.clk    (clk),
		.rd_en  (in_fire),
		.rd_addr(uni_addr),
		.rd_data(uni_rd),
		.wr_en  (uni_we),
		.wr_addr(uni_wa),
		.wr_data(uni_wd)
	);

	lngh_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(BI_DEPTH)
	) u_bi_ram (
		.clk    (clk),
		.rd_en  (in_fire),
		.rd_addr(bi_addr),
		.rd_data(bi_rd),
		.wr_en  (bi_we),
		.wr_addr(bi_wa),
		.wr_data(bi_wd)
	);

	lngh_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(TRI_DEPTH)
	) u_tri_ram (
		.clk    (clk),
		.rd_en  (in_fire),
		.rd_addr(tri_addr),
		.rd_data(tri_rd),
		.wr_en  (tri_we),
		.wr_addr(tri_wa),
		.wr_data(tri_wd)
	);

	// ------------------------------------------------------------------
	// Total, context and configuration
	// ------------------------------------------------------------------
	assign total_nxt = ctl_s1.feed_hit ? sat_inc(total_q) : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_code_q   <= FIRST_CODE_RST;
			last_code_q    <= LAST_CODE_RST;
			total_q        <= '0;
			recent_q       <= '0;
			recent_valid_q <= 1'b0;
			older_q        <= '0;
			older_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_FIRST_CODE: first_code_q <= cfg_data;
					REG_LAST_CODE:  last_code_q  <= cfg_data;
					default: ;
				endcase
			end
			// advance the context only on a counted byte
			if (s1_done && ctl_s1.feed_hit) begin
				total_q        <= total_nxt;
				older_q        <= recent_q;
				older_valid_q  <= recent_valid_q;
				recent_q       <= uni_addr_s1;
				recent_valid_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Response stage
	// ------------------------------------------------------------------
	lngh_resp #(
		.COUNT_BITS(COUNT_BITS)
	) u_resp (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (s1_done),
		.ctl        (ctl_s1),
		.total_nxt  (total_nxt),
		.uni_cnt    (uni_rd),
		.bi_cnt     (bi_rd),
		.tri_cnt    (tri_rd),
		.out_stall  (out_stall),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.accepted   (accepted),
		.count_value(count_value)
	);

`ifndef NO_ASSERTIONS
	// An older symbol never exists without a newer one.
	a_ctx_order: assert property (@(posedge clk) disable iff (!arst_n)
		older_valid_q |-> recent_valid_q)
		else $error("older context valid without recent context");

	// The sweep ends with no item in flight and no result pending.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_active) |-> (!s1_valid_q && !out_valid))
		else $error("item in flight during memory clear");

	// A counted byte raises the total by one unless it is saturated.
	a_total_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && ctl_s1.feed_hit && (total_q != '1)) |=>
		(total_q == COUNT_BITS'($past(total_q) + COUNT_BITS'(1))))
		else $error("symbol total did not advance");

	// An item that waits in the write-back stage keeps its unigram and trigram RAM read data.
	a_hold_read: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_done) |=> ($stable(uni_rd) && $stable(tri_rd)))
		else $error("read data lost while the result waits");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for letter_ngram_histogram: directed and random byte feeds,
// table reads and range reprogramming, checked against an in-bench n-gram predictor.
// Depends on lngh_pkg and the letter_ngram_histogram RTL only.
`timescale 1ns / 1ps

module testbench;
	import lngh_pkg::*;

	localparam int ALPHA = 32;

	// Codes the package leaves unnamed: the spare opcode and the empty table select.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] ORD_NONE  = 2'd0;

	// One input beat as the driver presents it.
	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] byte_val;
		logic [1:0] order;
		logic [4:0] idx_first;
		logic [4:0] idx_second;
		logic [4:0] idx_third;
	} beat_t;

	// One result beat as the predictor expects it.
	typedef struct packed {
		logic             accepted;
		logic [OUT_W-1:0] count;
	} tally_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FIRST_CODE;
	logic [7:0]           cfg_data = 8'd0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           opcode = 2'd0;
	logic [7:0]           byte_in = 8'd0;
	logic [1:0]           table_order = 2'd0;
	logic [4:0]           index_first = 5'd0;
	logic [4:0]           index_second = 5'd0;
	logic [4:0]           index_third = 5'd0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 accepted;
	logic [OUT_W-1:0]     count_value;

	letter_ngram_histogram #(
		.ALPHABET_SIZE(ALPHA),
		.COUNT_BITS(OUT_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.byte_in(byte_in),
		.table_order(table_order),
		.index_first(index_first),
		.index_second(index_second),
		.index_third(index_third),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.count_value(count_value)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: its own copy of the code range and every counter.
	// ------------------------------------------------------------------
	logic [7:0]       range_lo = FIRST_CODE_RST;
	logic [7:0]       range_hi = LAST_CODE_RST;
	bit   [OUT_W-1:0] uni_counts [ALPHA];
	bit   [OUT_W-1:0] pair_counts [ALPHA*ALPHA];
	bit   [OUT_W-1:0] triple_counts [ALPHA*ALPHA*ALPHA];
	bit   [OUT_W-1:0] symbols_seen = '0;
	logic [4:0]       last_sym = '0;
	logic             last_sym_ok = 1'b0;
	logic [4:0]       prior_sym = '0;
	logic             prior_sym_ok = 1'b0;

	beat_t  pending_beats [$];
	tally_t expected_tallies [$];
	int     mismatch_count = 0;
	logic   in_beat_taken = 1'b0;
	logic   no_idle = 1'b0;
	beat_t  next_beat;
	tally_t want;

	// Counters stick at all ones instead of wrapping.
	function automatic logic [OUT_W-1:0] sat_next(input logic [OUT_W-1:0] c);
		return (c == '1) ? c : c + OUT_W'(1);
	endfunction

	// Is this byte a symbol under the current code range?
	function automatic logic in_alphabet(input logic [7:0] b);
		return b >= range_lo && b <= range_hi && (int'(b) - int'(range_lo)) < ALPHA;
	endfunction

	// Apply one beat to the predictor state and return the result it must produce.
	function automatic tally_t tally(input beat_t bt);
		tally_t     r;
		logic [4:0] sym;
		r = '0;
		case (bt.opcode)
		OP_FEED: begin
			if (in_alphabet(bt.byte_val)) begin
				sym = 5'(bt.byte_val - range_lo);
				uni_counts[sym] = sat_next(uni_counts[sym]);
				if (last_sym_ok)
					pair_counts[{last_sym, sym}] = sat_next(pair_counts[{last_sym, sym}]);
				if (last_sym_ok && prior_sym_ok)
					triple_counts[{prior_sym, last_sym, sym}] =
						sat_next(triple_counts[{prior_sym, last_sym, sym}]);
				// shift the context window
				prior_sym    = last_sym;
				prior_sym_ok = last_sym_ok;
				last_sym     = sym;
				last_sym_ok  = 1'b1;
				symbols_seen = sat_next(symbols_seen);
				r.accepted   = 1'b1;
			end
			r.count = symbols_seen;
		end
		OP_READ: begin
			r.accepted = 1'b1;
			case (bt.order)
			ORD_UNI: r.count = uni_counts[bt.idx_third];
			ORD_BI:  r.count = pair_counts[{bt.idx_second, bt.idx_third}];
			ORD_TRI: r.count = triple_counts[{bt.idx_first, bt.idx_second, bt.idx_third}];
			default: r.count = '0;
			endcase
		end
		OP_TOTAL: begin
			r.accepted = 1'b1;
			r.count    = symbols_seen;
		end
		default: r = '0;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Driver: change inputs on the falling edge. Hold a beat until it is
	// taken, then either idle or advance to the next queued beat.
	// The result side stalls at random on the same edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_beat_taken) begin
			if (pending_beats.size() != 0 && (no_idle || $urandom_range(99, 0) >= 35)) begin
				next_beat = pending_beats.pop_front();
				in_valid     <= 1'b1;
				opcode       <= next_beat.opcode;
				byte_in      <= next_beat.byte_val;
				table_order  <= next_beat.order;
				index_first  <= next_beat.idx_first;
				index_second <= next_beat.idx_second;
				index_third  <= next_beat.idx_third;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= !no_idle && ($urandom_range(99, 0) < 35);
	end

	// ------------------------------------------------------------------
	// Monitor: sample on the rising edge. Check the result beat against the
	// oldest expectation first, then predict for an input beat taken now.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_tallies.size() == 0) begin
					$display("%0t: unexpected result beat, accepted=%0b count=%0d",
						$time, accepted, count_value);
					mismatch_count++;
				end else begin
					want = expected_tallies.pop_front();
					if (accepted !== want.accepted) begin
						$display("%0t: accepted mismatch, expected %0b, actual %0b",
							$time, want.accepted, accepted);
						mismatch_count++;
					end
					if (count_value !== want.count) begin
						$display("%0t: count_value mismatch, expected %0d, actual %0d",
							$time, want.count, count_value);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				expected_tallies.push_back(tally({opcode, byte_in, table_order,
					index_first, index_second, index_third}));
		end
		in_beat_taken <= arst_n && in_valid && !in_stall;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	logic [4:0] recent_fed [$];

	task automatic push_beat(input logic [1:0] op, input logic [7:0] b, input logic [1:0] ord,
			input logic [4:0] i1, input logic [4:0] i2, input logic [4:0] i3);
		pending_beats.push_back({op, b, ord, i1, i2, i3});
	endtask

	// Block until every queued beat is taken and every result has come back,
	// then let the pipeline drain before returning. Check on the rising edge,
	// where the driver's queue and valid are settled.
	task automatic wait_drained();
		while (pending_beats.size() != 0 || in_valid || expected_tallies.size() != 0)
			@(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Reprogram both ends of the code range; only called with the block idle.
	task automatic write_range(input logic [7:0] lo, input logic [7:0] hi);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_FIRST_CODE;
		cfg_data  <= lo;
		@(negedge clk);
		cfg_index <= REG_LAST_CODE;
		cfg_data  <= hi;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		range_lo = lo;
		range_hi = hi;
	endtask

	// Random beats: mostly in-range feeds so the context builds up, reads aimed
	// at the newest symbols so the pair and triple tables return real counts,
	// plus out-of-range bytes, totals and the spare opcode as noise.
	task automatic queue_random(input int n);
		beat_t b;
		int    roll;
		int    span;
		for (int k = 0; k < n; k++) begin
			b = $bits(beat_t)'($urandom);
			roll = $urandom_range(99, 0);
			if (roll < 60) begin
				b.opcode = OP_FEED;
				span = (int'(range_hi) < int'(range_lo) + ALPHA - 1) ?
					int'(range_hi) - int'(range_lo) + 1 : ALPHA;
				if (span > 0 && $urandom_range(99, 0) < 85)
					b.byte_val = 8'(int'(range_lo) + $urandom_range(span - 1, 0));
				if (in_alphabet(b.byte_val)) begin
					recent_fed.push_back(5'(b.byte_val - range_lo));
					if (recent_fed.size() > 3)
						void'(recent_fed.pop_front());
				end
			end else if (roll < 88) begin
				b.opcode = OP_READ;
				b.order = ($urandom_range(99, 0) < 6) ? ORD_NONE : 2'($urandom_range(3, 1));
				if (recent_fed.size() == 3 && $urandom_range(99, 0) < 70) begin
					b.idx_first  = recent_fed[0];
					b.idx_second = recent_fed[1];
					b.idx_third  = recent_fed[2];
				end
			end else if (roll < 95) begin
				b.opcode = OP_TOTAL;
			end else begin
				b.opcode = OP_UNUSED;
			end
			pending_beats.push_back(b);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed beats under the reset range 'a'..'s'.
		push_beat(OP_TOTAL, 8'd0, ORD_NONE, 5'd0, 5'd0, 5'd0);
		push_beat(OP_READ, 8'd0, ORD_UNI, 5'd0, 5'd0, 5'd0);
		push_beat(OP_FEED, 8'd97, ORD_NONE, 5'd0, 5'd0, 5'd0);
		push_beat(OP_FEED, 8'd98, ORD_NONE, 5'd0, 5'd0, 5'd0);
		push_beat(OP_FEED, 8'd99, ORD_NONE, 5'd0, 5'd0, 5'd0);
		// rejected bytes at both extremes and just outside the range, context holds; then the top code 's'
		push_beat(OP_FEED, 8'd0, ORD_NONE, 5'd31, 5'd31, 5'd31);
		push_beat(OP_FEED, 8'd255, ORD_NONE, 5'd0, 5'd0, 5'd0);
		push_beat(OP_FEED, 8'd96, ORD_NONE, 5'd0, 5'd0, 5'd0);
		push_beat(OP_FEED, 8'd116, ORD_NONE, 5'd0, 5'd0, 5'd0);
		push_beat(OP_FEED, 8'd115, ORD_NONE, 5'd0, 5'd0, 5'd0);
		push_beat(OP_READ, 8'd0, ORD_TRI, 5'd0, 5'd1, 5'd2);
		push_beat(OP_READ, 8'd0, ORD_TRI, 5'd1, 5'd2, 5'd18);
		push_beat(OP_READ, 8'd0, ORD_BI, 5'd0, 5'd2, 5'd18);
		push_beat(OP_READ, 8'd0, ORD_UNI, 5'd0, 5'd0, 5'd18);
		// empty table select, far corner of the triple table, spare opcode
		push_beat(OP_READ, 8'd255, ORD_NONE, 5'd31, 5'd31, 5'd31);
		push_beat(OP_READ, 8'd0, ORD_TRI, 5'd31, 5'd31, 5'd31);
		push_beat(OP_UNUSED, 8'd97, ORD_TRI, 5'd31, 5'd31, 5'd31);
		push_beat(OP_TOTAL, 8'd255, ORD_TRI, 5'd0, 5'd0, 5'd0);
		queue_random(240);

		// Range settings: full-width low corner, top 32 codes with no idling,
		// empty range, single codes at both ends, reset range, then random.
		for (int ph = 0; ph < 7; ph++) begin
			wait_drained();
			no_idle = 1'b0;
			case (ph)
			0: write_range(8'd0, 8'd255);
			1: begin
				write_range(8'd224, 8'd255);
				no_idle = 1'b1;
			end
			2: write_range(8'd200, 8'd100);
			3: write_range(8'd255, 8'd255);
			4: write_range(8'd0, 8'd0);
			5: write_range(FIRST_CODE_RST, LAST_CODE_RST);
			default: write_range(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)));
			endcase
			queue_random(240);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Hard stop: the reset sweep plus a heavily stalled run fits well inside.
	initial begin
		#1_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
design/lngh_pkg.sv
design/lngh_ram.sv
design/lngh_clear.sv
design/lngh_resp.sv
design/letter_ngram_histogram.sv
tb/testbench.sv
